>>> sv/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the repeating timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

    localparam int SLOTS  = 16;
    localparam int GROUPS = 16;
    localparam int SW     = $clog2(SLOTS);
    localparam int GW     = $clog2(GROUPS);

    localparam logic [32:0] ELAPSED_MAX = 33'h1_FFFF_FFFF;
    localparam logic [16:0] REP_MAX     = 17'h1_FFFF;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_REM   = 2'd2;
    localparam logic [1:0] OP_PAUSE = 2'd3;

    localparam logic [1:0] SC_SLOT  = 2'd0;
    localparam logic [1:0] SC_GROUP = 2'd1;
    localparam logic [1:0] SC_ALL   = 2'd2;

    localparam logic [1:0] K_FIRE = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_ACK  = 2'd2;

    // per-slot record held in the slot memory (valid bit lives in flops)
    typedef struct packed {
        logic [3:0]  owner;
        logic [31:0] period;
        logic [31:0] delay;
        logic [16:0] repeat_n;
        logic        paused;
        logic        dpend;
        logic        started;
        logic [32:0] elapsed;
        logic [16:0] fcount;
    } slot_rec_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_slot;
        logic [3:0]  fired_group;
        logic [32:0] elapsed_at_fire;
        logic        retired;
        logic        status;
        logic [4:0]  updated_count;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

>>> sv/rtt_slot_mem.sv
// ----------------------------------------------------------------------------
// rtt_slot_mem
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_slot_mem (
    input  wire                        clk,
    input  wire                        we,
    input  wire [rtt_pkg::SW-1:0]      waddr,
    input  wire rtt_pkg::slot_rec_t    wdata,
    input  wire [rtt_pkg::SW-1:0]      raddr,
    output rtt_pkg::slot_rec_t         rdata
);
    import rtt_pkg::*;

    slot_rec_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/rtt_slot_update.sv
// ----------------------------------------------------------------------------
// rtt_slot_update
// Tick update of one slot record: accumulate, compare, fire, retire.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_slot_update (
    input  wire rtt_pkg::slot_rec_t rec,
    input  wire [32:0]              dt,
    output rtt_pkg::slot_rec_t      nrec,
    output logic                    fired,
    output logic                    retire,
    output logic [32:0]             at
);
    import rtt_pkg::*;

    logic [33:0] sum;
    logic [32:0] el;
    logic        forever_n;
    logic [16:0] fc;

    always_comb
    begin
        nrec      = rec;
        fired     = 1'b0;
        retire    = 1'b0;
        forever_n = rec.repeat_n[16];
        sum       = {1'b0, rec.elapsed} + {1'b0, dt};
        el        = sum[33] ? ELAPSED_MAX : sum[32:0];
        fc        = rec.fcount;
        at        = el;
        if (!rec.started)
        begin
            nrec.started = 1'b1;
            nrec.elapsed = '0;
            nrec.fcount  = '0;
        end
        else
        begin
            nrec.elapsed = el;
            if (rec.dpend)
            begin
                if (el >= {1'b0, rec.delay})
                begin
                    fired        = 1'b1;
                    nrec.elapsed = el - {1'b0, rec.delay};
                    nrec.dpend   = 1'b0;
                    if (fc < REP_MAX)
                    begin
                        fc = fc + 17'd1;
                    end
                end
            end
            else if (el >= {1'b0, rec.period})
            begin
                fired        = 1'b1;
                nrec.elapsed = '0;
                if (!forever_n && fc < REP_MAX)
                begin
                    fc = fc + 17'd1;
                end
            end
            nrec.fcount = fc;
            // repeat is non-negative here, fire count is below 2^17
            retire = !forever_n && ({1'b0, fc} > {2'b00, rec.repeat_n[15:0]});
        end
    end

endmodule

`default_nettype wire

>>> sv/repeating_timer_table_top.sv
// ----------------------------------------------------------------------------
// repeating_timer_table_top
// Table of repeating timer slots with add, remove, pause and tick commands.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tick or command, op in tuser
//  m_axis    out        fire event, tick done or command ack, kind in tuser
//  cfg       in         time_scale (Q8.8)
//
//  A tick runs these steps in order from its accepting edge: scale multiply,
//  saturate plus first read, one read-modify-write per slot, then the done beat.
//  Add, single-slot and global commands read the slot and then send the ack beat;
//  a group command adds a walk over every slot after its ack beat.
//  Any beat that finds the output register still full waits until it is taken.
//  Reset clears valid bits, group pauses and control, sets scale to 1.0; no memory clear.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_timer_table_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: scope[1:0], slot[5:2], group[9:6], delta_time[41:10],
    // interval[73:42], repeat_count[90:74], first_delay[122:91],
    // pause_flag[123], zero fill [127:124]
    input  wire [127:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire [1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: fired_slot[3:0], fired_group[7:4], elapsed_at_fire[40:8],
    // retired[41], status[42], updated_count[47:43]
    output logic [47:0] m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [15:0]  cfg_data
);
    import rtt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_CRD  = 3'd5;
    localparam logic [2:0] S_CMD  = 3'd6;
    localparam logic [2:0] S_GW   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [15:0]       scale_reg;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [GROUPS-1:0] gpause_reg, gpause_next;
    logic [1:0]        op_reg;
    logic [123:0]      cmd_reg;
    logic [SW-1:0]     idx_reg, idx_next;
    logic [4:0]        upd_reg, upd_next;
    logic [47:0]       prod_reg;
    logic [32:0]       dt_reg;
    logic              out_v_reg, out_v_next;
    result_t           out_reg, out_next;

    logic [1:0]  c_scope;
    logic [3:0]  c_slot, c_group;
    logic [31:0] c_dt, c_int, c_fd;
    logic [16:0] c_rep;
    logic        c_flag;

    assign c_scope = cmd_reg[1:0];
    assign c_slot  = cmd_reg[5:2];
    assign c_group = cmd_reg[9:6];
    assign c_dt    = cmd_reg[41:10];
    assign c_int   = cmd_reg[73:42];
    assign c_rep   = cmd_reg[90:74];
    assign c_fd    = cmd_reg[122:91];
    assign c_flag  = cmd_reg[123];

    logic            we;
    logic [SW-1:0]   waddr, raddr;
    slot_rec_t       wdata, rdata, nrec;
    logic            fired, retire;
    logic [32:0]     at;
    logic [SW-1:0]   sidx;

    assign sidx = c_slot[SW-1:0];

    rtt_slot_mem u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    rtt_slot_update u_upd (
        .rec   (rdata),
        .dt    (dt_reg),
        .nrec  (nrec),
        .fired (fired),
        .retire(retire),
        .at    (at)
    );

    logic out_free;
    assign out_free      = !out_v_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {out_reg.updated_count, out_reg.status, out_reg.retired,
                            out_reg.elapsed_at_fire, out_reg.fired_group,
                            out_reg.fired_slot};

    logic active;
    assign active = valid_reg[idx_reg] && !rdata.paused && !gpause_reg[rdata.owner[GW-1:0]];

    logic cmd_rng;
    assign cmd_rng = (int'(c_slot) < SLOTS) && (int'(c_group) < GROUPS);

    logic slot_hit, walk_hit;
    assign slot_hit = valid_reg[sidx] && rdata.owner == c_group;
    assign walk_hit = valid_reg[idx_reg] && rdata.owner == c_group;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        upd_next    = upd_reg;
        valid_next  = valid_reg;
        gpause_next = gpause_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg && !m_axis_tready;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = nrec;
        raddr       = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                upd_next = '0;
                raddr    = '0;
                if (s_axis_tvalid)
                begin
                    state_next = (s_axis_tuser == OP_TICK) ? S_MUL : S_CRD;
                end
            end
            S_MUL:  state_next = S_RD;
            S_RD:   state_next = S_UPD;
            S_UPD:
            begin
                // a fire beat holds the walk until the output register is free
                if (!(active && fired) || out_free)
                begin
                    raddr    = idx_reg + SW'(1);
                    idx_next = idx_reg + SW'(1);
                    if (active)
                    begin
                        we       = 1'b1;
                        upd_next = upd_reg + 5'd1;
                        if (retire)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        if (fired)
                        begin
                            out_next                 = '0;
                            out_next.kind            = K_FIRE;
                            out_next.fired_slot      = 4'(idx_reg);
                            out_next.fired_group     = rdata.owner;
                            out_next.elapsed_at_fire = at;
                            out_next.retired         = retire;
                            out_v_next               = 1'b1;
                        end
                    end
                    if (idx_reg == SW'(SLOTS-1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next               = '0;
                    out_next.kind          = K_DONE;
                    out_next.updated_count = upd_reg;
                    out_next.last          = 1'b1;
                    out_v_next             = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            S_CRD:
            begin
                raddr      = sidx;
                state_next = S_CMD;
            end
            S_CMD:
            begin
                raddr = sidx;
                if (out_free)
                begin
                    out_next        = '0;
                    out_next.kind   = K_ACK;
                    out_next.last   = 1'b1;
                    out_next.status = 1'b1;
                    out_v_next      = 1'b1;
                    state_next      = S_IDLE;
                    if (cmd_rng)
                    begin
                        if (op_reg == OP_ADD)
                        begin
                            if (!valid_reg[sidx])
                            begin
                                we               = 1'b1;
                                waddr            = sidx;
                                wdata            = '0;
                                wdata.owner      = c_group;
                                wdata.period     = c_int;
                                wdata.delay      = c_fd;
                                wdata.repeat_n   = c_rep;
                                wdata.paused     = c_flag;
                                wdata.dpend      = (c_fd != 32'd0);
                                valid_next[sidx] = 1'b1;
                                out_next.status  = 1'b0;
                            end
                        end
                        else
                        begin
                            unique case (c_scope)
                                SC_SLOT:
                                begin
                                    if (slot_hit)
                                    begin
                                        if (op_reg == OP_REM)
                                        begin
                                            valid_next[sidx] = 1'b0;
                                        end
                                        else
                                        begin
                                            we           = 1'b1;
                                            waddr        = sidx;
                                            wdata        = rdata;
                                            wdata.paused = c_flag;
                                        end
                                        out_next.status = 1'b0;
                                    end
                                end
                                SC_GROUP:
                                begin
                                    gpause_next[c_group[GW-1:0]] = (op_reg == OP_PAUSE)
                                                                   && c_flag;
                                    out_next.status = 1'b0;
                                    idx_next        = '0;
                                    raddr           = '0;
                                    state_next      = S_GW;
                                end
                                SC_ALL:
                                begin
                                    gpause_next = {GROUPS{(op_reg == OP_PAUSE) && c_flag}};
                                    if (op_reg == OP_REM)
                                    begin
                                        valid_next = '0;
                                    end
                                    out_next.status = 1'b0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            S_GW:
            begin
                // group walk: write idx, read idx+1, never the same entry
                raddr    = idx_reg + SW'(1);
                idx_next = idx_reg + SW'(1);
                if (walk_hit)
                begin
                    if (op_reg == OP_REM)
                    begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    else
                    begin
                        we           = 1'b1;
                        wdata        = rdata;
                        wdata.paused = c_flag;
                    end
                end
                if (idx_reg == SW'(SLOTS-1))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            scale_reg  <= 16'd256;
            valid_reg  <= '0;
            gpause_reg <= '0;
            op_reg     <= '0;
            cmd_reg    <= '0;
            idx_reg    <= '0;
            upd_reg    <= '0;
            prod_reg   <= '0;
            dt_reg     <= '0;
            out_v_reg  <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            gpause_reg <= gpause_next;
            idx_reg    <= idx_next;
            upd_reg    <= upd_next;
            out_v_reg  <= out_v_next;
            out_reg    <= out_next;
            if (state_reg == S_IDLE && cfg_valid)
            begin
                scale_reg <= cfg_data;
            end
            if (state_reg == S_IDLE && s_axis_tvalid)
            begin
                op_reg  <= s_axis_tuser;
                cmd_reg <= s_axis_tdata[123:0];
            end
            if (state_reg == S_MUL)
            begin
                prod_reg <= 48'(c_dt) * 48'(scale_reg);
            end
            if (state_reg == S_RD)
            begin
                dt_reg <= (prod_reg[47:41] != 7'd0) ? ELAPSED_MAX : prod_reg[40:8];
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/repeating_timer_table_top_tb.sv
// ----------------------------------------------------------------------------
// repeating_timer_table_top_tb
// Self-checking bench for the timer table: commands and ticks go in over the
// input stream, a software copy of the table predicts every fire event, tick
// summary and acknowledge, and each output beat is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_timer_table_top_tb;
    import rtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [32:0] DT_MAX    = 33'h1_FFFF_FFFF;
    localparam logic [1:0]  SC_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    repeating_timer_table_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // shadow copy of the table
    logic [15:0] scale;
    logic        t_valid   [SLOTS];
    logic [3:0]  t_owner   [SLOTS];
    logic [31:0] t_period  [SLOTS];
    logic [31:0] t_delay   [SLOTS];
    int          t_repeat  [SLOTS];
    logic        t_paused  [SLOTS];
    logic        t_dpend   [SLOTS];
    logic        t_started [SLOTS];
    logic [32:0] t_elapsed [SLOTS];
    int          t_fcount  [SLOTS];
    logic        g_paused  [GROUPS];

    result_t expected_q[$];
    int      errors;
    int      beats_in;
    int      beats_out;
    int      fires_seen;
    int      burst_left;
    logic    stall_mode = 1'b0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    endtask

    function automatic result_t mk(input logic [1:0] k, input logic [3:0] s, input logic [3:0] g,
                                   input logic [32:0] el, input logic ret, input logic st,
                                   input logic [4:0] cnt, input logic lst);
        result_t r;
        r.kind = k; r.fired_slot = s; r.fired_group = g; r.elapsed_at_fire = el;
        r.retired = ret; r.status = st; r.updated_count = cnt; r.last = lst;
        return r;
    endfunction

    task automatic predict_tick(input logic [31:0] dt_raw);
        logic [47:0] prod;
        logic [33:0] sum;
        logic [32:0] dt;
        logic [32:0] at;
        logic        fired;
        logic        ret;
        int          upd;
        upd = 0;
        prod = 48'(dt_raw) * 48'(scale);
        dt = (prod[47:8] > {7'd0, DT_MAX}) ? DT_MAX : prod[40:8];
        for (int i = 0; i < SLOTS; i++) begin
            if (!t_valid[i] || t_paused[i] || g_paused[t_owner[i]])
                continue;
            upd++;
            if (!t_started[i]) begin
                t_started[i] = 1'b1;
                t_elapsed[i] = '0;
                t_fcount[i] = 0;
                continue;
            end
            fired = 1'b0;
            ret = 1'b0;
            at = '0;
            sum = {1'b0, t_elapsed[i]} + {1'b0, dt};
            t_elapsed[i] = sum[33] ? DT_MAX : sum[32:0];
            if (t_dpend[i]) begin
                if (t_elapsed[i] >= {1'b0, t_delay[i]}) begin
                    fired = 1'b1;
                    at = t_elapsed[i];
                    t_elapsed[i] = t_elapsed[i] - {1'b0, t_delay[i]};
                    if (t_fcount[i] < 'h1FFFF)
                        t_fcount[i]++;
                    t_dpend[i] = 1'b0;
                end
            end else if (t_elapsed[i] >= {1'b0, t_period[i]}) begin
                fired = 1'b1;
                at = t_elapsed[i];
                t_elapsed[i] = '0;
                if (t_repeat[i] >= 0 && t_fcount[i] < 'h1FFFF)
                    t_fcount[i]++;
            end
            if (t_repeat[i] >= 0 && t_fcount[i] > t_repeat[i]) begin
                t_valid[i] = 1'b0;
                ret = 1'b1;
            end
            if (fired)
                expected_q.push_back(mk(K_FIRE, 4'(i), t_owner[i], at, ret, 1'b0, 5'd0,
                                        1'b0));
        end
        expected_q.push_back(mk(K_DONE, 4'd0, 4'd0, 33'd0, 1'b0, 1'b0, 5'(upd), 1'b1));
    endtask

    task automatic predict_command(input logic [1:0] op, input logic [1:0] sc,
                                   input logic [3:0] s, input logic [3:0] g,
                                   input logic [31:0] iv, input logic [16:0] rep,
                                   input logic [31:0] fd, input logic flag);
        logic st;
        st = 1'b1;
        if (int'(s) < SLOTS && int'(g) < GROUPS) begin
            if (op == OP_ADD) begin
                if (!t_valid[s]) begin
                    t_valid[s] = 1'b1; t_owner[s] = g; t_period[s] = iv; t_delay[s] = fd;
                    t_repeat[s] = $signed(rep); t_paused[s] = flag; t_dpend[s] = fd != 0;
                    t_started[s] = 1'b0; t_elapsed[s] = '0; t_fcount[s] = 0;
                    st = 1'b0;
                end
            end else if (sc == SC_SLOT) begin
                if (t_valid[s] && t_owner[s] == g) begin
                    if (op == OP_REM) t_valid[s] = 1'b0;
                    else t_paused[s] = flag;
                    st = 1'b0;
                end
            end else if (sc == SC_GROUP) begin
                for (int i = 0; i < SLOTS; i++)
                    if (t_valid[i] && t_owner[i] == g) begin
                        if (op == OP_REM) t_valid[i] = 1'b0;
                        else t_paused[i] = flag;
                    end
                g_paused[g] = (op == OP_REM) ? 1'b0 : flag;
                st = 1'b0;
            end else if (sc == SC_ALL) begin
                if (op == OP_REM)
                    for (int i = 0; i < SLOTS; i++) t_valid[i] = 1'b0;
                for (int i = 0; i < GROUPS; i++)
                    g_paused[i] = (op == OP_REM) ? 1'b0 : flag;
                st = 1'b0;
            end
        end
        expected_q.push_back(mk(K_ACK, 4'd0, 4'd0, 33'd0, 1'b0, st, 5'd0, 1'b1));
    endtask

    // one input beat; sender bursts with random gaps between them
    task automatic send_beat(input logic [1:0] op, input logic [1:0] sc, input logic [3:0] s,
                             input logic [3:0] g, input logic [31:0] dt, input logic [31:0] iv,
                             input logic [16:0] rep, input logic [31:0] fd, input logic flag);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'b0000, flag, fd, rep, iv, dt, g, s, sc};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (op == OP_TICK) predict_tick(dt);
        else predict_command(op, sc, s, g, iv, rep, fd, flag);
        beats_in++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        scale = v;
    endtask

    function automatic logic [31:0] rnd_time();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 32'h0004_0000);
            2: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
        endcase
    endfunction

    function automatic logic [16:0] rnd_repeat();
        case ($urandom_range(0, 5))
            0: return 17'h1FFFF;
            1: return 17'($urandom);
            default: return 17'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic tick(input logic [31:0] dt);
        send_beat(OP_TICK, 2'($urandom), 4'($urandom), 4'($urandom), dt, $urandom,
                  17'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic test_directed();
        send_beat(OP_ADD, SC_SLOT, 4'd0, 4'd0, 32'd0, 32'h0001_0000, 17'd2, 32'h0000_8000,
                  1'b0);
        send_beat(OP_ADD, SC_SLOT, 4'd0, 4'd3, 32'd0, 32'd1, 17'd0, 32'd0, 1'b0); // busy slot
        send_beat(OP_ADD, SC_SLOT, 4'd15, 4'd15, 32'd0, 32'd0, 17'h1FFFF, 32'd0,
                  1'b0);                                                       // zero period
        send_beat(OP_ADD, SC_SLOT, 4'd7, 4'd5, 32'd0, 32'hFFFF_FFFF, 17'h1FFFF,
                  32'hFFFF_FFFF, 1'b1);
        send_beat(OP_ADD, SC_SLOT, 4'd8, 4'd5, 32'd0, 32'h0000_0100, 17'h0FFFF, 32'd0, 1'b0);
        tick(32'h0001_0000);
        tick(32'h0000_8000);
        tick(32'h0001_0000);
        tick(32'hFFFF_FFFF);
        send_beat(OP_PAUSE, SC_SLOT, 4'd7, 4'd5, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0);
        send_beat(OP_PAUSE, SC_SLOT, 4'd7, 4'd4, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0); // wrong owner
        tick(32'hFFFF_FFFF);
        tick(32'hFFFF_FFFF);
        send_beat(OP_PAUSE, SC_GROUP, 4'd0, 4'd9, 32'd0, 32'd0, 17'd0, 32'd0, 1'b1); // empty
        send_beat(OP_PAUSE, SC_GROUP, 4'd0, 4'd5, 32'd0, 32'd0, 17'd0, 32'd0, 1'b1);
        tick(32'h0000_0001);
        send_beat(OP_PAUSE, SC_ALL, 4'd0, 4'd0, 32'd0, 32'd0, 17'd0, 32'd0, 1'b1);
        tick(32'h0000_0001);
        send_beat(OP_PAUSE, SC_ALL, 4'd0, 4'd0, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0);
        send_beat(OP_PAUSE, SC_UNUSED, 4'd0, 4'd0, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0);
        send_beat(OP_REM, SC_SLOT, 4'd3, 4'd3, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0); // empty slot
        send_beat(OP_REM, SC_GROUP, 4'd0, 4'd5, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0);
        tick(32'h0000_0002);
        send_beat(OP_REM, SC_ALL, 4'd0, 4'd0, 32'd0, 32'd0, 17'd0, 32'd0, 1'b0);
        tick(32'h0000_0002);
    endtask

    task automatic test_scale(input logic [15:0] v, input int n);
        logic [1:0] op;
        logic [3:0] g;
        write_scale(v);
        for (int k = 0; k < n; k++) begin
            g = 4'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: op = OP_ADD;
                6, 7: op = OP_REM;
                8, 9: op = OP_PAUSE;
                default: op = OP_TICK;
            endcase
            if ($urandom_range(0, 7) == 0) g = 4'($urandom);
            if (op == OP_TICK)
                tick(rnd_time());
            else
                send_beat(op, ($urandom_range(0, 9) == 0) ? 2'($urandom)
                                                          : 2'($urandom_range(0, 1)),
                          4'($urandom), g, $urandom, rnd_time(), rnd_repeat(), rnd_time(),
                          (op == OP_ADD) ? ($urandom_range(0, 5) == 0) : 1'($urandom));
        end
    endtask

    // output checker and receiver stall pattern
    always @(posedge clk) begin
        result_t got;
        result_t exp;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4],
                   m_axis_tdata[40:8], m_axis_tdata[41], m_axis_tdata[42],
                   m_axis_tdata[47:43], m_axis_tlast};
            beats_out++;
            if (expected_q.size() == 0) begin
                report("unexpected beat", got, '0);
            end else begin
                exp = expected_q.pop_front();
                if (exp.kind == K_FIRE) fires_seen++;
                if (got.kind != exp.kind) report("kind", got.kind, exp.kind);
                if (got.fired_slot != exp.fired_slot)
                    report("fired_slot", got.fired_slot, exp.fired_slot);
                if (got.fired_group != exp.fired_group)
                    report("fired_group", got.fired_group, exp.fired_group);
                if (got.elapsed_at_fire != exp.elapsed_at_fire)
                    report("elapsed_at_fire", got.elapsed_at_fire, exp.elapsed_at_fire);
                if (got.retired != exp.retired) report("retired", got.retired, exp.retired);
                if (got.status != exp.status) report("status", got.status, exp.status);
                if (got.updated_count != exp.updated_count)
                    report("updated_count", got.updated_count, exp.updated_count);
                if (got.last != exp.last) report("last", got.last, exp.last);
            end
        end
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        errors = 0; beats_in = 0; beats_out = 0; fires_seen = 0; burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        scale = 16'd256;
        for (int i = 0; i < SLOTS; i++) begin
            t_valid[i] = 0; t_owner[i] = 0; t_period[i] = 0; t_delay[i] = 0;
            t_repeat[i] = 0; t_paused[i] = 0; t_dpend[i] = 0; t_started[i] = 0;
            t_elapsed[i] = 0; t_fcount[i] = 0;
        end
        for (int i = 0; i < GROUPS; i++) g_paused[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_scale(16'hFFFF, 40);
        test_scale(16'd0, 20);
        test_scale(16'd256, 90);
        test_scale(16'd1, 20);
        test_scale(16'($urandom_range(128, 2048)), 80);
        drain();

        $display("Sent %0d input beats, checked %0d result beats (%0d fire events).",
                 beats_in, beats_out, fires_seen);
        $display("Covered add/remove/pause at slot, group and global scope, scales 0..65535.");
        if (errors == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

>>> repeating_timer_table_top.f
sv/rtt_pkg.sv
sv/rtt_slot_mem.sv
sv/rtt_slot_update.sv
sv/repeating_timer_table_top.sv
tb/repeating_timer_table_top_tb.sv
